// File: rtl/ofp_pkg.sv
// ----------------------------------------------------------------------------
// ofp_pkg - optical flow frame parser shared definitions
// Frame constants, register indexes, state encoding and the structs that
// pass between the parser stages.
// ----------------------------------------------------------------------------
package ofp_pkg;

  localparam logic [7:0] HDR0    = 8'hFE;
  localparam logic [7:0] HDR1    = 8'h04;
  localparam logic [7:0] TRAILER = 8'hAA;

  // Bytes in one frame; the index counts header bytes too.
  localparam logic [3:0] FRAME_LEN = 4'd11;
  // First index that carries a stored byte (data, sum, quality).
  localparam logic [3:0] STORE_FIRST = 4'd2;
  // Data bytes D0..D5 fold into the running sum.
  localparam logic [3:0] DATA_LAST = 4'd7;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned SUM_SLOT    = 6;
  localparam int unsigned QUAL_SLOT   = 7;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT       = 8'd1;

  localparam logic [7:0] QUALITY_THRESHOLD_RST = 8'd25;
  localparam logic [7:0] FAULT_LIMIT_RST       = 8'd60;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // A checked frame handed from the deframer to the statistics stage.
  typedef struct packed {
    logic        valid;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] raw_h;
    logic [7:0]  quality;
  } frame_t;

  // One result word as delivered on the output channel.
  typedef struct packed {
    logic signed [16:0] flow_x;
    logic signed [15:0] flow_y;
    logic signed [15:0] height_mm;
    logic [7:0]         quality;
    logic               flow_ok;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic [15:0]        frame_count;
  } res_t;

  // Occupancy of the output buffer.
  typedef struct packed {
    logic head_valid;
    logic skid_full;
  } buf_status_t;

endpackage

// File: rtl/ofp_if.sv
// ----------------------------------------------------------------------------
// ofp_if - channel interfaces of the optical flow frame parser
// Byte input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
interface ofp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ofp_result_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] flow_x;
  logic signed [15:0] flow_y;
  logic signed [15:0] height_mm;
  logic [7:0]         quality;
  logic               flow_ok;
  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;
  logic [15:0]        frame_count;

  modport source (
    output valid, output flow_x, output flow_y, output height_mm, output quality,
    output flow_ok, output sum_x, output sum_y, output frame_count, input ready
  );
  modport sink (
    input valid, input flow_x, input flow_y, input height_mm, input quality,
    input flow_ok, input sum_x, input sum_y, input frame_count, output ready
  );
endinterface

interface ofp_cfg_if
  import ofp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/optical_flow_frame_parser.sv
// ----------------------------------------------------------------------------
// optical_flow_frame_parser - flow sensor frame parser
// Hunts 11-byte flow frames in a byte stream and reports flow, height,
// quality, a validity flag, running flow sums and a frame count.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per word. Frame is FE 04 D0..D5 SUM QUAL AA,
//         where SUM is the 8-bit wrapping sum of D0..D5.
//   res : one result word per frame whose trailer and sum both match; bad
//         frames are dropped without a word and hunting restarts.
//   cfg : register writes, always ready; index 0 is the quality threshold,
//         index 1 the fault limit, other indexes are ignored. Write only
//         while no frame is in flight.
//   Throughput: one byte per cycle. The only backpressure comes from the
//   two-word output buffer: rx.ready drops while it holds two results, or
//   one result with another frame one stage behind it.
//   Result path: after the trailer byte is taken, the result word passes the
//   frame register, then the output register.
//   Receiver stall: the head word holds steady, a second result waits in the
//   skid stage, and bytes keep flowing until a second result is waiting or due.
//   Reset: synchronous, active high. Clears the hunt state, the fault run,
//   the ok flag, the sums and the count, and reloads the registers with
//   threshold 25 and fault limit 60.
// ----------------------------------------------------------------------------
module optical_flow_frame_parser
  import ofp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ofp_byte_if.sink      rx,
  ofp_result_if.source  res,
  ofp_cfg_if.sink       cfg
);

  frame_t      frame;
  logic        push;
  res_t        push_data;
  buf_status_t status;
  logic        rx_accept;

  // Take a byte only if the buffer can absorb the result it may cause on
  // top of anything already in flight.
  assign rx.ready = !((status.head_valid && status.skid_full) ||
                      (frame.valid && (status.head_valid || status.skid_full)));
  assign rx_accept = rx.valid && rx.ready;

  ofp_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx_accept),
    .rx_byte (rx.rx_byte),
    .frame   (frame)
  );

  ofp_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .frame     (frame),
    .push      (push),
    .push_data (push_data)
  );

  ofp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .res       (res),
    .status    (status)
  );

endmodule

// File: rtl/ofp_deframer.sv
// ----------------------------------------------------------------------------
// ofp_deframer - header hunt and frame capture
// Tracks the frame position byte by byte, keeps the data bytes and a running
// sum, and registers one checked frame when trailer and sum both match.
// ----------------------------------------------------------------------------
module ofp_deframer
  import ofp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  phase_t      phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [7:0]  data_sum, data_sum_next;
  logic [7:0]  frame_bytes [STORE_DEPTH];
  logic        store_en;
  logic        frame_done;
  logic        frame_good;

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    data_sum_next   = data_sum;
    store_en        = 1'b0;
    frame_done      = 1'b0;
    frame_good      = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == HDR0) begin
            phase_next      = PH_HDR;
            byte_index_next = 4'd1;
          end else begin
            phase_next      = PH_HUNT;
            byte_index_next = 4'd0;
          end
        end
        PH_HDR: begin
          // a bad second header byte is not retried as a first header
          if (rx_byte == HDR1) begin
            phase_next      = PH_BODY;
            byte_index_next = STORE_FIRST;
            data_sum_next   = 8'd0;
          end else begin
            phase_next      = PH_HUNT;
            byte_index_next = 4'd0;
          end
        end
        PH_BODY: begin
          store_en        = 1'b1;
          byte_index_next = byte_index + 4'd1;
          if (byte_index >= STORE_FIRST && byte_index <= DATA_LAST) begin
            data_sum_next = data_sum + rx_byte;
          end
          if (byte_index_next == FRAME_LEN) begin
            phase_next      = PH_HUNT;
            byte_index_next = 4'd0;
            frame_done      = 1'b1;
            frame_good      = (rx_byte == TRAILER) && (data_sum == frame_bytes[SUM_SLOT]);
          end
        end
        default: begin
          phase_next      = PH_HUNT;
          byte_index_next = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_index  <= 4'd0;
      frame.valid <= 1'b0;
    end else begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      frame.valid <= frame_good;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    data_sum <= data_sum_next;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (store_en && byte_index == STORE_FIRST + 4'(i)) begin
        frame_bytes[i] <= rx_byte;
      end
    end
    if (frame_done) begin
      frame.raw_x   <= {frame_bytes[1], frame_bytes[0]};
      frame.raw_y   <= {frame_bytes[3], frame_bytes[2]};
      frame.raw_h   <= {frame_bytes[5], frame_bytes[4]};
      frame.quality <= frame_bytes[QUAL_SLOT];
    end
  end

endmodule

// File: rtl/ofp_stats.sv
// ----------------------------------------------------------------------------
// ofp_stats - flow statistics and configuration registers
// Negates X, updates the quality fault run, the flow sums and the frame
// count, and forms the result word for each checked frame.
// ----------------------------------------------------------------------------
module ofp_stats
  import ofp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ofp_cfg_if.sink   cfg,
  input  frame_t    frame,
  output logic      push,
  output res_t      push_data
);

  logic [7:0]  quality_threshold;
  logic [7:0]  fault_limit;
  logic [7:0]  bad_run, bad_run_next;
  logic        ok_flag, ok_flag_next;
  logic [31:0] accum_x, accum_x_next;
  logic [31:0] accum_y, accum_y_next;
  logic [15:0] frames_seen, frames_seen_next;
  logic [16:0] fx;
  logic [8:0]  run_inc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_threshold <= QUALITY_THRESHOLD_RST;
      fault_limit       <= FAULT_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_QUALITY_THRESHOLD: quality_threshold <= cfg.data;
        CFG_FAULT_LIMIT:       fault_limit       <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fx               = 17'd0 - {frame.raw_x[15], frame.raw_x};
    accum_x_next     = accum_x + {{15{fx[16]}}, fx};
    accum_y_next     = accum_y + {{16{frame.raw_y[15]}}, frame.raw_y};
    frames_seen_next = frames_seen + 16'd1;
    run_inc          = {1'b0, bad_run} + 9'd1;
    if (frame.quality < quality_threshold) begin
      // saturate the run at the limit and drop the ok flag
      if (run_inc > {1'b0, fault_limit}) begin
        bad_run_next = fault_limit;
        ok_flag_next = 1'b0;
      end else begin
        bad_run_next = run_inc[7:0];
        ok_flag_next = ok_flag;
      end
    end else begin
      bad_run_next = 8'd0;
      ok_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_run     <= 8'd0;
      ok_flag     <= 1'b0;
      accum_x     <= 32'd0;
      accum_y     <= 32'd0;
      frames_seen <= 16'd0;
    end else if (frame.valid) begin
      bad_run     <= bad_run_next;
      ok_flag     <= ok_flag_next;
      accum_x     <= accum_x_next;
      accum_y     <= accum_y_next;
      frames_seen <= frames_seen_next;
    end
  end

  assign push                  = frame.valid;
  assign push_data.flow_x      = $signed(fx);
  assign push_data.flow_y      = $signed(frame.raw_y);
  assign push_data.height_mm   = $signed(frame.raw_h);
  assign push_data.quality     = frame.quality;
  assign push_data.flow_ok     = ok_flag_next;
  assign push_data.sum_x       = $signed(accum_x_next);
  assign push_data.sum_y       = $signed(accum_y_next);
  assign push_data.frame_count = frames_seen_next;

endmodule

// File: rtl/ofp_outbuf.sv
// ----------------------------------------------------------------------------
// ofp_outbuf - two-word result buffer
// Output register with a skid stage behind it, so a stalled receiver does
// not hold up the byte input until a second result is waiting or due.
// ----------------------------------------------------------------------------
module ofp_outbuf
  import ofp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  res_t          push_data,
  ofp_result_if.source  res,
  output buf_status_t   status
);

  logic head_valid;
  logic skid_full;
  res_t head;
  res_t skid;
  logic pop;

  assign pop = head_valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_full  <= 1'b0;
    end else if (pop) begin
      if (skid_full) begin
        skid_full <= push;
      end else begin
        head_valid <= push;
      end
    end else if (!head_valid) begin
      head_valid <= push;
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_full) begin
        head <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (!head_valid) begin
      if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

  assign status.head_valid = head_valid;
  assign status.skid_full  = skid_full;

  assign res.valid       = head_valid;
  assign res.flow_x      = head.flow_x;
  assign res.flow_y      = head.flow_y;
  assign res.height_mm   = head.height_mm;
  assign res.quality     = head.quality;
  assign res.flow_ok     = head.flow_ok;
  assign res.sum_x       = head.sum_x;
  assign res.sum_y       = head.sum_y;
  assign res.frame_count = head.frame_count;

endmodule

// File: rtl/ofp_checker.sv
// ----------------------------------------------------------------------------
// ofp_checker - port-level checks for the flow frame parser
// Watches the top-level channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
module ofp_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [16:0] flow_x
);

  logic rx_accept;

  assign rx_accept = rx_valid && rx_ready;

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // a new result follows an accepted trailer byte via the frame and output registers
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(rx_accept, 2))
    else $error("result without an accepted byte two cycles before");

  // the input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid)
    else $error("byte input stalled with no result pending");

  // negated X flow stays within -32767 .. 32768
  a_flow_x_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((flow_x[16] == flow_x[15]) && (flow_x != 17'h18000)) ||
                  (flow_x == 17'h08000))
    else $error("flow_x outside the negated 16-bit range");

endmodule

bind optical_flow_frame_parser ofp_checker u_ofp_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_valid  (rx.valid),
  .rx_ready  (rx.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .flow_x    (res.flow_x)
);
